@@ rtl/pstg_pkg.sv @@
package pstg_pkg;

  localparam int PHASE_BITS       = 32;
  localparam int TABLE_INDEX_BITS = 12;
  localparam int MAX_CHANNELS     = 32;
  localparam int MAX_FRAMES       = 8192;

  localparam int TABLE_SIZE = 1 << TABLE_INDEX_BITS;
  localparam int QUARTER    = TABLE_SIZE >> 2;
  // quarter-wave index 0..QUARTER
  localparam int QIDX_W     = TABLE_INDEX_BITS - 1;

  localparam int MAG_W       = 14;
  localparam int SAMPLE_W    = 16;
  localparam int CH_IDX_W    = 5;
  localparam int CH_CNT_W    = 6;
  localparam int FPP_W       = 14;
  localparam int FRAME_CNT_W = 13;

  localparam int DEFAULT_CHANNELS = (MAX_CHANNELS < 2) ? MAX_CHANNELS : 2;
  localparam int DEFAULT_FRAMES   = (MAX_FRAMES < 480) ? MAX_FRAMES : 480;

  typedef enum logic [1:0] {
    CFG_PHASE_STEP        = 2'd0,
    CFG_CHANNEL_COUNT     = 2'd1,
    CFG_PACKET_FRAMES     = 2'd2
  } cfg_reg_t;

  // one frame handed from the phase stage to the channel serializer
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [CH_IDX_W-1:0]        last_ch;
    logic                       pkt_end;
  } frame_t;

  typedef logic [MAG_W-1:0] quarter_t [0:QUARTER];

  // pi in Q60
  localparam logic [63:0] PI_Q60  = 64'h3243F6A8885A308D;
  localparam logic [63:0] AMP_NUM = 64'd98301;
  localparam logic [63:0] AMP_DEN = 64'd10;

  // (2n)(2n+1) for the odd Taylor terms of sin
  localparam logic [63:0] SERIES_DIV [1:19] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272,
    64'd342, 64'd420, 64'd506, 64'd600, 64'd702, 64'd812, 64'd930,
    64'd1056, 64'd1190, 64'd1332, 64'd1482
  };

  function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  // trunc(9830.1 * sin(pi/2 * j / QUARTER)), exact integer series
  function automatic logic [MAG_W-1:0] quarter_entry(input logic [63:0] j);
    logic [63:0] half_pi;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] s46;
    logic [63:0] scaled;
    half_pi = PI_Q60 >> 1;
    x = (half_pi / QUARTER) * j + ((half_pi % QUARTER) * j) / QUARTER;
    x2 = mul_q60(x, x);
    term = x;
    sum = x;
    for (int n = 1; n < 20; n++) begin
      term = mul_q60(term, x2) / SERIES_DIV[n];
      if (n % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    s46 = sum >> 14;
    scaled = ((s46 * AMP_NUM) / AMP_DEN) >> 46;
    return scaled[MAG_W-1:0];
  endfunction

  function automatic quarter_t build_quarter_wave();
    quarter_t w;
    for (int j = 0; j <= QUARTER; j++) begin
      w[j] = quarter_entry(64'(j));
    end
    return w;
  endfunction

  function automatic logic [CH_CNT_W-1:0] eff_channels(input logic [CH_CNT_W-1:0] c);
    if (c == '0 || int'(c) > MAX_CHANNELS) begin
      return CH_CNT_W'(DEFAULT_CHANNELS);
    end
    return c;
  endfunction

  function automatic logic [FPP_W-1:0] eff_frames(input logic [FPP_W-1:0] f);
    if (f == '0 || int'(f) > MAX_FRAMES) begin
      return FPP_W'(DEFAULT_FRAMES);
    end
    return f;
  endfunction

endpackage

@@ rtl/pstg_if.sv @@
interface pstg_in_if;
  logic valid;
  logic ready;
  logic tick;

  modport source (output valid, output tick, input ready);
  modport sink (input valid, input tick, output ready);
endinterface

interface pstg_out_if;
  import pstg_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_value;
  logic [CH_IDX_W-1:0]        channel_index;
  logic                       frame_last;
  logic                       packet_last;

  modport source (output valid, output sample_value, output channel_index,
                  output frame_last, output packet_last, input ready);
  modport sink (input valid, input sample_value, input channel_index,
                input frame_last, input packet_last, output ready);
endinterface

@@ rtl/pstg_rom.sv @@
module pstg_rom (
  input  logic                          clk,
  input  logic                          en,
  input  logic [pstg_pkg::QIDX_W-1:0]   addr,
  output logic [pstg_pkg::MAG_W-1:0]    data_r
);
  import pstg_pkg::*;

  // quarter sine wave, magnitude only
  localparam quarter_t WAVE = build_quarter_wave();

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= WAVE[addr];
    end
  end

endmodule

@@ rtl/pstg_front.sv @@
module pstg_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [pstg_pkg::PHASE_BITS-1:0]    phase_step,
  input  logic [pstg_pkg::CH_CNT_W-1:0]      chans,
  input  logic [pstg_pkg::FPP_W-1:0]         frames,
  pstg_in_if.sink                            in_ch,
  input  logic                               s1_take,
  output logic                               s1_valid,
  output pstg_pkg::frame_t                   s1_frame
);
  import pstg_pkg::*;

  logic [PHASE_BITS-1:0]       phase_r;
  logic [FRAME_CNT_W-1:0]      frame_cnt_r;
  logic                        s1_valid_r;
  logic                        neg_r;
  logic [CH_IDX_W-1:0]         last_ch_r;
  logic                        pkt_end_r;

  logic [TABLE_INDEX_BITS-1:0] pos;
  logic [QIDX_W-1:0]           half;
  logic [QIDX_W-1:0]           rom_addr;
  logic [MAG_W-1:0]            mag;
  logic [FPP_W-1:0]            frame_cnt_inc;
  logic                        fire;
  logic                        pkt_end;

  assign in_ch.ready = !s1_valid_r || s1_take;
  assign fire        = in_ch.valid && in_ch.ready && in_ch.tick;

  // fold the table index onto the quarter wave; top bit gives the sign
  assign pos  = phase_r[PHASE_BITS-1 -: TABLE_INDEX_BITS];
  assign half = pos[QIDX_W-1:0];

  always_comb begin
    if (half <= QIDX_W'(QUARTER)) begin
      rom_addr = half;
    end else begin
      rom_addr = QIDX_W'(0) - half;
    end
  end

  pstg_rom u_rom (
    .clk    (clk),
    .en     (fire),
    .addr   (rom_addr),
    .data_r (mag)
  );

  assign frame_cnt_inc = FPP_W'(frame_cnt_r) + FPP_W'(1);
  assign pkt_end       = (frame_cnt_inc >= frames);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= '0;
      frame_cnt_r <= '0;
      s1_valid_r  <= 1'b0;
    end else begin
      if (fire) begin
        phase_r     <= phase_r + phase_step;
        frame_cnt_r <= pkt_end ? '0 : frame_cnt_inc[FRAME_CNT_W-1:0];
        s1_valid_r  <= 1'b1;
      end else if (s1_take) begin
        s1_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      neg_r     <= pos[TABLE_INDEX_BITS-1];
      last_ch_r <= CH_IDX_W'(chans - CH_CNT_W'(1));
      pkt_end_r <= pkt_end;
    end
  end

  assign s1_valid         = s1_valid_r;
  assign s1_frame.sample  = neg_r ? SAMPLE_W'(0) - SAMPLE_W'(mag) : SAMPLE_W'(mag);
  assign s1_frame.last_ch = last_ch_r;
  assign s1_frame.pkt_end = pkt_end_r;

endmodule

@@ rtl/pstg_ser.sv @@
module pstg_ser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              s1_valid,
  input  pstg_pkg::frame_t  s1_frame,
  output logic              s1_take,
  pstg_out_if.source        out_ch
);
  import pstg_pkg::*;

  logic                       f_valid_r;
  logic signed [SAMPLE_W-1:0] f_sample_r;
  logic [CH_IDX_W-1:0]        f_last_r;
  logic                       f_pkt_end_r;
  logic [CH_IDX_W-1:0]        f_ch_r;

  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic [CH_IDX_W-1:0]        out_ch_r;
  logic                       out_frame_last_r;
  logic                       out_packet_last_r;

  logic                       out_adv;
  logic                       emit;
  logic                       at_last;
  logic                       f_done;

  assign out_adv = !out_valid_r || out_ch.ready;
  assign emit    = f_valid_r && out_adv;
  assign at_last = (f_ch_r == f_last_r);
  assign f_done  = emit && at_last;
  assign s1_take = s1_valid && (!f_valid_r || f_done);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r   <= 1'b0;
      f_ch_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_adv) begin
        out_valid_r <= f_valid_r;
      end
      if (s1_take) begin
        f_valid_r <= 1'b1;
        f_ch_r    <= '0;
      end else if (f_done) begin
        f_valid_r <= 1'b0;
      end else if (emit) begin
        f_ch_r    <= f_ch_r + CH_IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      f_sample_r  <= s1_frame.sample;
      f_last_r    <= s1_frame.last_ch;
      f_pkt_end_r <= s1_frame.pkt_end;
    end
    if (emit) begin
      out_sample_r      <= f_sample_r;
      out_ch_r          <= f_ch_r;
      out_frame_last_r  <= at_last;
      out_packet_last_r <= at_last && f_pkt_end_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.sample_value  = out_sample_r;
  assign out_ch.channel_index = out_ch_r;
  assign out_ch.frame_last    = out_frame_last_r;
  assign out_ch.packet_last   = out_packet_last_r;

  a_ch_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    f_valid_r |-> f_ch_r <= f_last_r)
    else $error("channel counter past last channel");

  a_pkt_on_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_packet_last_r |-> out_frame_last_r)
    else $error("packet end without frame end");

  a_load_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    s1_take |=> f_valid_r && f_ch_r == '0)
    else $error("frame load did not restart channel count");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    f_valid_r && !out_adv |=> f_valid_r && $stable(f_ch_r))
    else $error("frame state moved while output stalled");

endmodule

@@ rtl/packetized_sine_tone_generator.sv @@
// Packetized sine tone generator.
// in_ch  : valid/ready words carrying tick. tick=1 makes one audio frame; tick=0
//          is taken and dropped. The frame's sample is read from the phase
//          before it advances by phase_step.
// out_ch : valid/ready words, one per channel: sample_value, channel_index,
//          frame_last on the last channel, packet_last on the last channel of
//          the packet's last frame.
// cfg_*  : write-only registers, index 0 phase_step, 1 channel_count,
//          2 packet length in frames; out-of-range counts fall back to defaults.
//          Write only while idle.
// Path: the first word of a frame is valid once its accepted tick has passed
//   the sine ROM read, the frame buffer load and then the output register.
// Throughput: the output register emits one word per cycle while out_ch.ready is
//   high, one word per channel of each frame; a tick is taken every cycle while the
//   frame buffer ahead of the serializer has room, so frames stream with no gap.
// Reset: phase, frame counter and all valid flags clear at once; registers
//   return to phase_step 0, channel_count 2, packet length 480.
// Stall: when out_ch.ready is low the output word holds, the serializer and
//   then the input stage fill up and in_ch.ready drops; nothing is lost.
module packetized_sine_tone_generator (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [1:0]                       cfg_index,
  input  logic [pstg_pkg::PHASE_BITS-1:0]  cfg_data,
  pstg_in_if.sink                          in_ch,
  pstg_out_if.source                       out_ch
);
  import pstg_pkg::*;

  // config held already range-checked
  logic [PHASE_BITS-1:0] step_r;
  logic [CH_CNT_W-1:0]   chans_r;
  logic [FPP_W-1:0]      frames_r;

  logic                  s1_valid;
  logic                  s1_take;
  frame_t                s1_frame;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r   <= '0;
      chans_r  <= CH_CNT_W'(DEFAULT_CHANNELS);
      frames_r <= FPP_W'(DEFAULT_FRAMES);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_PHASE_STEP:        step_r   <= cfg_data;
        CFG_CHANNEL_COUNT:     chans_r  <= eff_channels(cfg_data[CH_CNT_W-1:0]);
        CFG_PACKET_FRAMES:     frames_r <= eff_frames(cfg_data[FPP_W-1:0]);
        default: ;
      endcase
    end
  end

  // phase accumulator, packet counter, sine lookup
  pstg_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .phase_step (step_r),
    .chans      (chans_r),
    .frames     (frames_r),
    .in_ch      (in_ch),
    .s1_take    (s1_take),
    .s1_valid   (s1_valid),
    .s1_frame   (s1_frame)
  );

  // fans the frame out to one word per channel
  pstg_ser u_ser (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid),
    .s1_frame (s1_frame),
    .s1_take  (s1_take),
    .out_ch   (out_ch)
  );

endmodule

@@ dv/pstg_tone_sb_pkg.sv @@
package pstg_tone_sb_pkg;
  import pstg_pkg::*;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [CH_IDX_W-1:0]        channel;
    logic                       frame_last;
    logic                       packet_last;
  } tone_word_t;

  localparam real HALF_PI    = 1.5707963267948966;
  // 0.3 of full scale, as 98301/10
  localparam real AMP_TENTHS = 98301.0;

  class tone_scoreboard;
    logic signed [SAMPLE_W-1:0] sine_rom [TABLE_SIZE];
    logic [PHASE_BITS-1:0]      phase_step;
    logic [PHASE_BITS-1:0]      phase_acc;
    logic [CH_CNT_W-1:0]        channel_count;
    logic [FPP_W-1:0]           packet_frames;
    logic [FRAME_CNT_W-1:0]     frame_pos;
    tone_word_t                 pending_words [$];
    int                         mismatch_count;
    int                         word_count;

    function new();
      int  j;
      int  mag;
      real amp;
      // full wave from quarter-wave symmetry, truncated toward zero
      for (int k = 0; k < TABLE_SIZE; k++) begin
        j = k % (TABLE_SIZE / 2);
        if (j > QUARTER) begin
          j = TABLE_SIZE / 2 - j;
        end
        amp = AMP_TENTHS * $sin(HALF_PI * j / QUARTER) / 10.0;
        mag = $rtoi(amp);
        sine_rom[k] = (k >= TABLE_SIZE / 2) ? SAMPLE_W'(-mag) : SAMPLE_W'(mag);
      end
      phase_step        = '0;
      phase_acc         = '0;
      channel_count     = CH_CNT_W'(DEFAULT_CHANNELS);
      packet_frames     = FPP_W'(DEFAULT_FRAMES);
      frame_pos         = '0;
      mismatch_count    = 0;
      word_count        = 0;
    endfunction

    function void configure(input logic [1:0] idx, input logic [PHASE_BITS-1:0] data);
      case (idx)
        CFG_PHASE_STEP:        phase_step = data;
        CFG_CHANNEL_COUNT:     channel_count = data[CH_CNT_W-1:0];
        CFG_PACKET_FRAMES:     packet_frames = data[FPP_W-1:0];
        default: ;
      endcase
    endfunction

    // one accepted input word; a tick expands into one word per channel
    function void note_tick(input logic tick);
      int                         chans;
      int                         frames;
      logic                       frame_end;
      logic signed [SAMPLE_W-1:0] sample;
      tone_word_t                 w;
      if (!tick) begin
        return;
      end
      chans = int'(channel_count);
      if (chans == 0 || chans > MAX_CHANNELS) begin
        chans = DEFAULT_CHANNELS;
      end
      frames = int'(packet_frames);
      if (frames == 0 || frames > MAX_FRAMES) begin
        frames = DEFAULT_FRAMES;
      end
      sample    = sine_rom[phase_acc[PHASE_BITS-1 -: TABLE_INDEX_BITS]];
      phase_acc = phase_acc + phase_step;
      frame_end = (int'(frame_pos) + 1 >= frames);
      frame_pos = frame_end ? '0 : frame_pos + 1'b1;
      for (int ch = 0; ch < chans; ch++) begin
        w.sample      = sample;
        w.channel     = CH_IDX_W'(ch);
        w.frame_last  = (ch == chans - 1);
        w.packet_last = w.frame_last && frame_end;
        pending_words.push_back(w);
      end
    endfunction

    function int pending();
      return pending_words.size();
    endfunction

    task report_mismatch(input string what);
      $display("MISMATCH word %0d: %s", word_count, what);
      mismatch_count++;
    endtask

    task check_word(input logic signed [SAMPLE_W-1:0] sample, input logic [CH_IDX_W-1:0] channel,
                    input logic frame_last, input logic packet_last);
      tone_word_t exp_w;
      word_count++;
      if (pending_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word, sample %0d channel %0d", sample, channel));
        return;
      end
      exp_w = pending_words.pop_front();
      if (sample !== exp_w.sample) begin
        report_mismatch($sformatf("sample_value %0d, want %0d", sample, exp_w.sample));
      end
      if (channel !== exp_w.channel) begin
        report_mismatch($sformatf("channel_index %0d, want %0d", channel, exp_w.channel));
      end
      if (frame_last !== exp_w.frame_last) begin
        report_mismatch($sformatf("frame_last %b, want %b", frame_last, exp_w.frame_last));
      end
      if (packet_last !== exp_w.packet_last) begin
        report_mismatch($sformatf("packet_last %b, want %b", packet_last, exp_w.packet_last));
      end
    endtask
  endclass

endpackage

@@ dv/packetized_sine_tone_generator_tb.sv @@
module packetized_sine_tone_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pstg_pkg::*;
  import pstg_tone_sb_pkg::*;

  localparam int         CYCLE_LIMIT  = 400000;
  localparam int         RANDOM_WORDS = 440;
  // The path runs through ROM read, frame buffer and output register; leave some
  // margin for dropped ticks still in flight before touching registers
  localparam int         DRAIN_CYCLES = 8;
  localparam int         IDLE_PCT     = 25;
  // index 3 decodes to no register
  localparam logic [1:0] CFG_NO_REG   = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [1:0]            cfg_index;
  logic [PHASE_BITS-1:0] cfg_data;

  pstg_in_if  in_ch ();
  pstg_out_if out_ch ();

  packetized_sine_tone_generator u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  tone_scoreboard tone_sb;
  bit             quiet_run = 1'b0;  // both sides run without idling
  int             cycle_count = 0;
  int             random_words = 0;

  always #6 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result side: every word taken at an edge is checked against the oldest
  // expected word, then ready is re-rolled for the next cycle.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      tone_sb.check_word(out_ch.sample_value, out_ch.channel_index,
                         out_ch.frame_last, out_ch.packet_last);
    end
    out_ch.ready <= quiet_run || ($urandom_range(99) >= IDLE_PCT);
  end

  // One register write per edge; cfg_we stays high so back-to-back writes
  // never lower and raise it in the same step. Caller drops it afterwards.
  task automatic cfg_write(input logic [1:0] idx, input logic [PHASE_BITS-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    tone_sb.configure(idx, data);
  endtask

  task automatic program_tone(input logic [PHASE_BITS-1:0] step,
                              input logic [PHASE_BITS-1:0] chans,
                              input logic [PHASE_BITS-1:0] frames);
    cfg_write(CFG_PHASE_STEP, step);
    cfg_write(CFG_CHANNEL_COUNT, chans);
    cfg_write(CFG_PACKET_FRAMES, frames);
    cfg_we <= 1'b0;
  endtask

  // Offer one input word, with random gaps ahead of it; returns at the edge
  // where it was taken, valid still high.
  task automatic send_word(input logic tick);
    while (!quiet_run && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.tick  <= tick;
    @(posedge clk);
    while (!in_ch.ready) begin
      @(posedge clk);
    end
    tone_sb.note_tick(tick);
  endtask

  // Stop sending and wait until every expected word has come out. Pending
  // count is read on the falling edge, clear of the checker's updates.
  task automatic wait_empty();
    in_ch.valid <= 1'b0;
    do begin
      @(negedge clk);
    end while (tone_sb.pending() != 0);
    @(posedge clk);
  endtask

  task automatic settle();
    wait_empty();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Random register set: mostly legal, with extremes and out-of-range counts
  // mixed in. Upper data bits are random; the block keeps only the field.
  task automatic random_tone_setup();
    logic [PHASE_BITS-1:0] step;
    logic [PHASE_BITS-1:0] chans;
    logic [PHASE_BITS-1:0] frames;
    int                    pick;
    pick = $urandom_range(9);
    case (pick)
      0:       step = '0;
      1:       step = '1;
      2:       step = PHASE_BITS'($urandom_range(1, 4096)) << 12;
      default: step = $urandom;
    endcase
    chans = $urandom;
    pick  = $urandom_range(9);
    if (pick == 0) begin
      chans[CH_CNT_W-1:0] = $urandom_range(1) ? '0 : CH_CNT_W'($urandom_range(33, 63));
    end else if (pick == 1) begin
      chans[CH_CNT_W-1:0] = $urandom_range(1) ? CH_CNT_W'(1) : CH_CNT_W'(MAX_CHANNELS);
    end else begin
      chans[CH_CNT_W-1:0] = CH_CNT_W'($urandom_range(1, MAX_CHANNELS));
    end
    frames = $urandom;
    pick   = $urandom_range(19);
    if (pick < 2) begin
      frames[FPP_W-1:0] = $urandom_range(1) ? '0 : FPP_W'($urandom_range(8193, 16383));
    end else if (pick == 2) begin
      frames[FPP_W-1:0] = $urandom_range(1) ? FPP_W'(1) : FPP_W'(MAX_FRAMES);
    end else if (pick == 3) begin
      frames[FPP_W-1:0] = FPP_W'($urandom_range(1, MAX_FRAMES));
    end else if (pick < 9) begin
      frames[FPP_W-1:0] = FPP_W'($urandom_range(1, 64));
    end else begin
      frames[FPP_W-1:0] = FPP_W'($urandom_range(1, 8));
    end
    program_tone(step, chans, frames);
  endtask

  initial begin
    int burst;
    int phase_no;
    logic tick;

    tone_sb      = new();
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_index    <= CFG_PHASE_STEP;
    cfg_data     <= '0;
    in_ch.valid  <= 1'b0;
    in_ch.tick   <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Reset values: step 0 holds phase at zero, two channels, long packet.
    // A dropped tick sits between two real ones.
    send_word(1'b1);
    send_word(1'b0);
    send_word(1'b1);
    settle();

    // Quarter-turn steps land on 0, +peak, 0, -peak; single channel, and
    // the packet closes on the first frame since the counter is already 2.
    program_tone(32'h4000_0000, 32'd1, 32'd3);
    repeat (5) send_word(1'b1);
    settle();

    // All-ones step (phase walks backward), widest frame, one-frame packets.
    program_tone('1, MAX_CHANNELS, 32'd1);
    repeat (3) send_word(1'b1);
    settle();

    // Zero counts fall back to defaults; stray write to the unused index.
    cfg_write(CFG_NO_REG, $urandom);
    program_tone(32'h0010_0000, 32'hFFFF_FFC0, 32'hFFFF_C000);
    repeat (2) send_word(1'b1);
    settle();

    // Counts one past the maximum also fall back.
    program_tone(32'h8000_0000, 32'd33, 32'd8193);
    send_word(1'b1);
    send_word(1'b0);
    send_word(1'b1);
    settle();

    // Longest packet, then packet length cut below the current position:
    // next frame must close the packet and restart the count.
    program_tone(32'h1234_5678, 32'd31, MAX_FRAMES);
    repeat (4) send_word(1'b1);
    settle();
    cfg_write(CFG_PACKET_FRAMES, 32'd2);
    cfg_we <= 1'b0;
    repeat (3) send_word(1'b1);
    settle();

    // Random phases: new register set each phase, mostly ticks with a few
    // dropped words as noise. Phase 1 stalls the sender midway until the
    // output drains; phase 3 runs with no idling on either side.
    phase_no = 0;
    while (random_words < RANDOM_WORDS) begin
      random_tone_setup();
      quiet_run = (phase_no == 3);
      burst     = $urandom_range(20, 60);
      for (int i = 0; i < burst; i++) begin
        if (phase_no == 1 && i == burst / 2) begin
          wait_empty();
        end
        tick = ($urandom_range(99) >= 12);
        send_word(tick);
        random_words++;
      end
      settle();
      quiet_run = 1'b0;
      phase_no++;
    end

    settle();
    if (tone_sb.pending() != 0) begin
      tone_sb.report_mismatch($sformatf("%0d words never arrived", tone_sb.pending()));
    end
    if (tone_sb.mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
